// ===== sv/sdip_pkg.sv =====
`timescale 1ns / 1ps

package sdip_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int DATA_W         = 8;
  localparam int TOKEN_W        = 32;
  localparam int MAXC_W         = 6;
  localparam int CNT_W          = 7;

  localparam logic [MAXC_W-1:0] MAXC_RESET = 6'd31;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 7'd127;

  localparam logic [DATA_W-1:0] CH_NUL   = 8'h00;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [DATA_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BAD   = 3'd1,
    ST_RANGE = 3'd2,
    ST_LONG  = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_BAD   = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_LONG  = 2'd3
  } err_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] value;
    status_t            status;
    logic               last;
  } result_t;

endpackage

// ===== sv/sdip_core.sv =====
`timescale 1ns / 1ps

module sdip_core #(
  parameter int VALUE_BITS = sdip_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [sdip_pkg::DATA_W-1:0] char_byte,
  input  logic [sdip_pkg::MAXC_W-1:0] max_chars,
  output logic                        res_valid,
  output sdip_pkg::result_t           res
);
  import sdip_pkg::*;

  localparam int NW = VALUE_BITS + 4;

  logic                  inside_r, inside_nxt;
  logic                  neg_r, neg_nxt;
  logic                  seen_r, seen_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  err_t                  err_r, err_nxt;

  logic                  is_zero, is_space, is_sign, dec_char;
  logic [3:0]            digit;
  logic                  cur_neg;
  logic [CNT_W-1:0]      cur_cnt, cnt_inc;
  logic [VALUE_BITS-1:0] cur_mag;
  err_t                  cur_err;
  logic                  cur_seen;
  logic [NW-1:0]         mag_ext, next_val, limit;
  logic                  too_long, fin_long;
  logic [VALUE_BITS-1:0] signed_val;

  always_comb begin
    is_zero  = (char_byte == CH_NUL);
    is_space = (char_byte == CH_SPACE);
    is_sign  = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
    dec_char = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    digit    = 4'(char_byte - CH_ZERO);

    // a new token starts from a clean slate
    cur_neg  = inside_r ? neg_r  : 1'b0;
    cur_seen = inside_r ? seen_r : 1'b0;
    cur_cnt  = inside_r ? cnt_r  : '0;
    cur_mag  = inside_r ? mag_r  : '0;
    cur_err  = inside_r ? err_r  : ERR_NONE;

    cnt_inc  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    too_long = (cnt_inc > {1'b0, max_chars});

    mag_ext  = NW'(cur_mag);
    next_val = (mag_ext << 3) + (mag_ext << 1) + NW'(digit);
    limit    = (NW'(1) << (VALUE_BITS - 1)) - NW'(!cur_neg);
  end

  always_comb begin
    inside_nxt = inside_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    cnt_nxt    = cnt_r;
    mag_nxt    = mag_r;
    err_nxt    = err_r;
    if (step) begin
      if (is_zero || is_space) begin
        inside_nxt = 1'b0;
        neg_nxt    = 1'b0;
        seen_nxt   = 1'b0;
        cnt_nxt    = '0;
        mag_nxt    = '0;
        err_nxt    = ERR_NONE;
      end else begin
        inside_nxt = 1'b1;
        neg_nxt    = cur_neg;
        seen_nxt   = cur_seen;
        cnt_nxt    = cnt_inc;
        mag_nxt    = cur_mag;
        err_nxt    = cur_err;
        if (too_long) begin
          err_nxt = ERR_LONG;
        end else if ((cur_cnt == '0) && is_sign) begin
          neg_nxt = (char_byte == CH_MINUS);
        end else if (dec_char) begin
          seen_nxt = 1'b1;
          if (cur_err == ERR_NONE) begin
            if (next_val > limit) begin
              err_nxt = ERR_RANGE;
            end else begin
              mag_nxt = next_val[VALUE_BITS-1:0];
            end
          end
        end else if (cur_err == ERR_NONE) begin
          err_nxt = ERR_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      cnt_r    <= '0;
      mag_r    <= '0;
      err_r    <= ERR_NONE;
    end else begin
      inside_r <= inside_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      cnt_r    <= cnt_nxt;
      mag_r    <= mag_nxt;
      err_r    <= err_nxt;
    end
  end

  // closing a token
  always_comb begin
    fin_long   = (cnt_r > {1'b0, max_chars});
    signed_val = neg_r ? (VALUE_BITS'(0) - mag_r) : mag_r;
    res_valid  = step && (is_zero || (is_space && inside_r));
    res.last   = is_zero;
    res.value  = '0;
    if (!inside_r) begin
      res.status = ST_NONE;
    end else if (fin_long) begin
      res.status = ST_LONG;
    end else if (err_r != ERR_NONE) begin
      res.status = status_t'({1'b0, err_r});
    end else if (!seen_r) begin
      res.status = ST_BAD;
    end else begin
      res.status = ST_OK;
      res.value  = TOKEN_W'(signed'(signed_val));
    end
  end

endmodule

// ===== sv/space_delimited_int_parser.sv =====
`timescale 1ns / 1ps
// channel  | direction | ports                              | payload
// ---------+-----------+------------------------------------+--------------------------------
// in_      | slave     | in_tvalid in_tready in_tdata       | char_byte
// out_     | master    | out_tvalid out_tready out_tdata    | token_value, tuser parse_status,
//          |           | out_tuser out_tlast                | tlast end_of_argument
// cfg_     | write     | cfg_wr_en cfg_wr_data              | max_token_chars
//
// One item per cycle sustained while out_tready keeps up; an item runs input register -> token
// update -> result register; out_tvalid rises when a token's result enters the result register.
// The token update (multiply by ten, add, range compare) sits in one register-to-register path.
// rst_n is synchronous: clears both stages and token state, max_token_chars returns to 31.
// A stall on out_tready holds the result and the token update, even for items with no result;
// the input register still takes one more item, then in_tready drops.

module space_delimited_int_parser #(
  parameter int VALUE_BITS = sdip_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sdip_pkg::DATA_W-1:0]  in_tdata,    // [7:0] char_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sdip_pkg::TOKEN_W-1:0] out_tdata,   // [31:0] token_value
  output logic [2:0]                   out_tuser,   // [2:0] parse_status
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [sdip_pkg::MAXC_W-1:0]  cfg_wr_data
);
  import sdip_pkg::*;

  logic               in_valid_r, in_valid_nxt;
  logic [DATA_W-1:0]  in_data_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r;
  logic [MAXC_W-1:0]  max_r;
  logic               proc_go;
  logic               res_valid;
  result_t            res;

  assign proc_go   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_go;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (proc_go) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (proc_go && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= MAXC_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (proc_go && res_valid) begin
      out_res_r <= res;
    end
  end

  sdip_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc_go),
    .char_byte (in_data_r),
    .max_chars (max_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

// ===== sv/sdip_checker.sv =====
`timescale 1ns / 1ps

module sdip_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [sdip_pkg::TOKEN_W-1:0] out_tdata,
  input logic [2:0]                   out_tuser,
  input logic                         out_tlast
);
  import sdip_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("nonzero value with error status");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NONE) |-> out_tlast)
    else $error("no-token result without end mark");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind space_delimited_int_parser sdip_checker u_sdip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sdip_pkg::*;

  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_CHARS  = 205;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [TOKEN_W-1:0] out_tdata;
  logic [2:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_wr_en   = 1'b0;
  logic [MAXC_W-1:0] cfg_wr_data = '0;

  space_delimited_int_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [DATA_W-1:0] char_queue[$];
  result_t           token_results[$];

  int in_gap_max    = 10;
  int out_stall_max = 10;
  int in_wait       = 0;
  int out_wait      = 0;
  int idle_cycles   = 0;
  int error_count   = 0;
  int chars_sent    = 0;
  int results_seen  = 0;
  int queued_chars  = 0;
  int settings_used = 0;
  int status_hits[5];
  logic [MAXC_W-1:0] limit_now = MAXC_RESET;

  // predictor state
  logic               tok_open;
  logic               tok_neg;
  logic               tok_digit;
  logic [CNT_W-1:0]   tok_count;
  logic [TOKEN_W-1:0] tok_mag;
  err_t               tok_err;
  logic [MAXC_W-1:0]  max_chars;

  string boundary_text[12] = '{
    "2147483647", "2147483648", "-2147483648", "-2147483649",
    "+2147483647", "0", "-0", "4294967296", "99999999999",
    "000000000000012", "214748364", "21474836470"
  };

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_token_state();
    tok_open  = 1'b0;
    tok_neg   = 1'b0;
    tok_digit = 1'b0;
    tok_count = '0;
    tok_mag   = '0;
    tok_err   = ERR_NONE;
  endtask

  task automatic parse_char(input logic [DATA_W-1:0] c);
    result_t     r;
    logic [35:0] lim;
    logic [35:0] nxt;
    logic        first;
    if (c == CH_NUL || c == CH_SPACE) begin
      if (tok_open) begin
        if (tok_count > max_chars) r.status = ST_LONG;
        else if (tok_err != ERR_NONE) r.status = status_t'({1'b0, tok_err});
        else if (!tok_digit) r.status = ST_BAD;
        else r.status = ST_OK;
        r.value = (r.status == ST_OK) ? (tok_neg ? -tok_mag : tok_mag) : '0;
        r.last  = (c == CH_NUL);
        token_results.push_back(r);
      end else if (c == CH_NUL) begin
        r.value  = '0;
        r.status = ST_NONE;
        r.last   = 1'b1;
        token_results.push_back(r);
      end
      clear_token_state();
    end else begin
      if (!tok_open) begin
        clear_token_state();
        tok_open = 1'b1;
      end
      first = (tok_count == 0);
      if (tok_count != CNT_MAX) tok_count = tok_count + 1'b1;
      if (tok_count > max_chars) begin
        tok_err = ERR_LONG;
      end else if (first && (c == CH_PLUS || c == CH_MINUS)) begin
        tok_neg = (c == CH_MINUS);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        tok_digit = 1'b1;
        if (tok_err == ERR_NONE) begin
          lim = tok_neg ? 36'h080000000 : 36'h07FFFFFFF;
          nxt = {4'd0, tok_mag} * 36'd10 + {28'd0, c - CH_ZERO};
          if (nxt > lim) tok_err = ERR_RANGE;
          else tok_mag = nxt[31:0];
        end
      end else if (tok_err == ERR_NONE) begin
        tok_err = ERR_BAD;
      end
    end
  endtask

  task automatic flag(input string what, input longint want_v, input longint got_v);
    error_count++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_wait > 0) begin
        in_wait   <= in_wait - 1;
        in_tvalid <= 1'b0;
      end else if (char_queue.size() > 0) begin
        in_tdata  <= char_queue.pop_front();
        in_tvalid <= 1'b1;
        in_wait   <= $urandom_range(in_gap_max, 0);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // predictor, receiver and result check
  always @(posedge clk) begin : rx_side
    int      stall;
    result_t want;
    stall = out_wait;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
      max_chars = MAXC_RESET;
      clear_token_state();
    end else begin
      if (in_tvalid && in_tready) begin
        parse_char(in_tdata);
        chars_sent++;
      end
      if (cfg_wr_en) max_chars = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (token_results.size() == 0) begin
          error_count++;
          $display("%0t ns: result with nothing pending, got value %0d status %0d last %0d",
                   $time, $signed(out_tdata), out_tuser, out_tlast);
        end else begin
          want = token_results.pop_front();
          if (out_tdata !== want.value)
            flag("token_value", $signed(want.value), $signed(out_tdata));
          if (out_tuser !== want.status) flag("parse_status", want.status, out_tuser);
          if (out_tlast !== want.last) flag("end_of_argument", want.last, out_tlast);
          results_seen++;
          status_hits[want.status]++;
        end
        stall = $urandom_range(out_stall_max, 0);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        out_wait   <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        out_wait   <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, token_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_byte(input logic [DATA_W-1:0] b);
    char_queue.push_back(b);
    queued_chars++;
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) add_byte(CH_ZERO + 8'($urandom_range(9, 0)));
  endtask

  task automatic add_sign();
    add_byte($urandom_range(1, 0) ? CH_MINUS : CH_PLUS);
  endtask

  task automatic add_token();
    int               len;
    logic [DATA_W-1:0] b;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        if ($urandom_range(2, 0) == 0) add_sign();
        add_digits($urandom_range(10, 1));
      end
      4: add_text(boundary_text[$urandom_range(11, 0)]);
      5: begin
        len = int'(limit_now) + $urandom_range(2, 0) - 1;
        if (len < 1) len = 1;
        if ($urandom_range(1, 0) == 0) begin
          add_sign();
          len = (len > 1) ? len - 1 : len;
        end
        add_digits(len);
      end
      6: begin
        case ($urandom_range(3, 0))
          0: begin
            add_digits($urandom_range(3, 1));
            add_sign();
            add_digits($urandom_range(3, 0));
          end
          1: add_sign();
          2: begin
            add_sign();
            add_sign();
            add_digits($urandom_range(3, 1));
          end
          default: begin
            add_digits($urandom_range(3, 0));
            add_byte(8'($urandom_range(126, 58)));
            add_digits($urandom_range(3, 0));
          end
        endcase
      end
      7: begin
        repeat ($urandom_range(6, 1)) begin
          b = 8'($urandom_range(255, 1));
          if (b == CH_SPACE) b = 8'hFF;
          add_byte(b);
        end
      end
      8: begin
        if ($urandom_range(15, 0) == 0) add_digits($urandom_range(130, 128));
        else add_digits($urandom_range(3, 1));
      end
      default: begin
        // overflow then a bad char, or a bad char then overflow
        if ($urandom_range(1, 0) == 0) begin
          add_digits($urandom_range(13, 11));
          add_byte(8'h78);
        end else begin
          add_byte(8'h41);
          add_digits($urandom_range(13, 11));
        end
      end
    endcase
  endtask

  task automatic add_argument();
    int n;
    n = $urandom_range(4, 0);
    for (int i = 0; i < n; i++) begin
      repeat ((i == 0) ? $urandom_range(2, 0) : $urandom_range(3, 1)) add_byte(CH_SPACE);
      add_token();
    end
    repeat ($urandom_range(1, 0)) add_byte(CH_SPACE);
    add_byte(CH_NUL);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (char_queue.size() > 0 || in_tvalid || token_results.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [MAXC_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    limit_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int plan[8];
    plan = '{63, 1, 0, 10, 5, 20, 0, 31};
    plan[6] = $urandom_range(63, 0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes of the value range, no-token argument, lone sign, misplaced sign
    add_text("-2147483648");
    add_byte(CH_SPACE);
    add_text("2147483648");
    add_byte(CH_NUL);
    add_byte(CH_NUL);
    add_text(" + 1-");
    add_byte(8'hFF);
    add_byte(CH_NUL);
    wait_idle();

    foreach (plan[p]) begin
      in_gap_max    = (p % 3 == 1) ? 0 : 10;
      out_stall_max = (p % 4 == 2) ? 0 : 10;
      write_limit(plan[p][MAXC_W-1:0]);
      @(negedge clk);
      queued_chars = 0;
      while (queued_chars < PHASE_CHARS) add_argument();
      wait_idle();
    end

    $display("Sent %0d characters, checked %0d results under %0d limit settings.",
             chars_sent, results_seen, settings_used + 1);
    $display("Statuses: ok %0d, bad format %0d, out of range %0d, too long %0d, no token %0d",
             status_hits[ST_OK], status_hits[ST_BAD], status_hits[ST_RANGE],
             status_hits[ST_LONG], status_hits[ST_NONE]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
